// ===== sv/cassette_fsk_tape_encoder_assert.svh =====
// assertion macros for the cassette fsk tape encoder
`ifndef CASSETTE_FSK_TAPE_ENCODER_ASSERT_SVH
`define CASSETTE_FSK_TAPE_ENCODER_ASSERT_SVH

// same-cycle implication, held off during reset
`define CFE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CFE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after reset is seen
`define CFE_ASSERT_RESET(name, cons, msg) \
  name: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== sv/cfe_pkg.sv =====
package cfe_pkg;

  // default widths of the tick timer and the nonzero byte counter
  localparam int DEF_TIMER_WIDTH = 16;
  localparam int DEF_COUNT_WIDTH = 24;

  // width of the count field of a result
  localparam int OUT_COUNT_WIDTH = 24;

  // tape byte values
  localparam logic [7:0] LEADER_BYTE = 8'h55;
  localparam logic [7:0] SYNC_BYTE   = 8'h3C;
  localparam logic [7:0] BLOCK_TYPE_MAX = 8'h01;

  // leader run saturation
  localparam logic [9:0] RUN_MAX = 10'd1023;

  // playback phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PAD   = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_HALF_ZERO   = 3'd0;
  localparam logic [2:0] REG_HALF_ONE    = 3'd1;
  localparam logic [2:0] REG_LEADER_LEN  = 3'd2;
  localparam logic [2:0] REG_ORPHAN_MIN  = 3'd3;
  localparam logic [2:0] REG_TRAILER     = 3'd4;
  localparam logic [2:0] REG_ENABLE      = 3'd5;

  // configuration reset values
  localparam logic [15:0] RST_HALF_ZERO  = 16'd416;
  localparam logic [15:0] RST_HALF_ONE   = 16'd208;
  localparam logic [9:0]  RST_LEADER_LEN = 10'd256;
  localparam logic [9:0]  RST_ORPHAN_MIN = 10'd64;
  localparam logic [7:0]  RST_TRAILER    = 8'd16;
  localparam logic        RST_ENABLE     = 1'b1;

  // input item as offered
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic [7:0] next_byte;
    logic       next_valid;
    logic       is_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                       audio_level;
    logic                       ready_res;
    logic                       dropped;
    logic [OUT_COUNT_WIDTH-1:0] nonzero_count;
  } out_item_t;

  // configuration write
  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_leader;
    logic       is_sync;
    logic       sync_ok;
    logic       is_zero;
    logic       is_last;
    logic [7:0] data_byte;
  } cls_item_t;

endpackage

// ===== sv/cfe_chan_if.sv =====
interface cfe_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/cfe_front.sv =====
module cfe_front
  import cfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cfe_chan_if.sink   req,
  output logic       q_valid,
  output cls_item_t  q_data,
  input  logic       q_pop
);

  // two-entry queue towards the back end
  cls_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cls_item_t  cls;

  // classify the offered item
  always_comb begin
    cls.is_tick   = (req.data.req_type == REQ_TICK);
    cls.is_leader = (req.data.data_byte == LEADER_BYTE);
    cls.is_sync   = (req.data.data_byte == SYNC_BYTE);
    cls.sync_ok   = req.data.next_valid && (req.data.next_byte <= BLOCK_TYPE_MAX);
    cls.is_zero   = (req.data.data_byte == 8'd0);
    cls.is_last   = req.data.is_last;
    cls.data_byte = req.data.data_byte;
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/cfe_back.sv =====
module cfe_back
  import cfe_pkg::*;
#(
  parameter int TIMER_WIDTH = DEF_TIMER_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cls_item_t  q_data,
  output logic       q_pop,
  cfe_chan_if.sink   cfg,
  cfe_chan_if.source res
);

  localparam int HW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // configuration registers
  logic [15:0] half_zero;
  logic [15:0] half_one;
  logic [9:0]  leader_length;
  logic [9:0]  orphan_minimum;
  logic [7:0]  trailer_bytes;
  logic        enable;

  // playback state
  logic [9:0]             leader_run, leader_run_next;
  logic [9:0]             pad_remaining, pad_remaining_next;
  logic [7:0]             trailer_remaining, trailer_remaining_next;
  logic [7:0]             held_byte, held_byte_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [2:0]             bit_position, bit_position_next;
  logic                   second_half, second_half_next;
  logic [TIMER_WIDTH-1:0] tick_timer, tick_timer_next;
  logic [1:0]             output_phase, output_phase_next;
  logic                   line_level, line_level_next;
  logic [COUNT_WIDTH-1:0] nonzero_total, nonzero_total_next;
  logic                   dropped;

  // output register
  logic      out_valid;
  out_item_t out_data;

  // half period selection
  logic [15:0] half_raw;
  logic [15:0] half_nz;
  logic [HW-1:0] half_ext;
  logic [HW-1:0] tmax_ext;
  logic [HW-1:0] half;
  logic [HW:0]   timer_inc;
  logic          expire;

  // leader padding
  logic       do_pad;
  logic [9:0] pad_value;

  assign cfg.ready = 1'b1;
  assign q_pop     = q_valid && (!out_valid || res.ready);
  assign res.valid = out_valid;
  assign res.data  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_zero      <= RST_HALF_ZERO;
      half_one       <= RST_HALF_ONE;
      leader_length  <= RST_LEADER_LEN;
      orphan_minimum <= RST_ORPHAN_MIN;
      trailer_bytes  <= RST_TRAILER;
      enable         <= RST_ENABLE;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_HALF_ZERO:  half_zero      <= cfg.data.value;
        REG_HALF_ONE:   half_one       <= cfg.data.value;
        REG_LEADER_LEN: leader_length  <= cfg.data.value[9:0];
        REG_ORPHAN_MIN: orphan_minimum <= cfg.data.value[9:0];
        REG_TRAILER:    trailer_bytes  <= cfg.data.value[7:0];
        REG_ENABLE:     enable         <= cfg.data.value[0];
        default: ;
      endcase
    end
  end

  // current half period, zero taken as one, clamped to the timer range
  always_comb begin
    half_raw  = shift_byte[bit_position] ? half_one : half_zero;
    half_nz   = (half_raw == 16'd0) ? 16'd1 : half_raw;
    half_ext  = HW'(half_nz);
    tmax_ext  = HW'({TIMER_WIDTH{1'b1}});
    half      = (half_ext > tmax_ext) ? tmax_ext : half_ext;
    timer_inc = {1'b0, HW'(tick_timer)} + {{HW{1'b0}}, 1'b1};
    expire    = !(timer_inc < {1'b0, half});
  end

  // leader tracking decision for a byte
  always_comb begin
    pad_value = leader_length - leader_run;
    if (q_data.is_sync) begin
      do_pad = q_data.sync_ok && (leader_run != 10'd0) && (leader_run < leader_length);
    end else begin
      do_pad = (leader_run != 10'd0) && (leader_run >= orphan_minimum)
               && (leader_run < leader_length);
    end
  end

  // state update for one item
  always_comb begin
    leader_run_next        = leader_run;
    pad_remaining_next     = pad_remaining;
    trailer_remaining_next = trailer_remaining;
    held_byte_next         = held_byte;
    shift_byte_next        = shift_byte;
    bit_position_next      = bit_position;
    second_half_next       = second_half;
    tick_timer_next        = tick_timer;
    output_phase_next      = output_phase;
    line_level_next        = line_level;
    nonzero_total_next     = nonzero_total;
    dropped                = 1'b0;

    if (q_data.is_tick) begin
      if (output_phase != PH_IDLE) begin
        if (!enable) begin
          // playback abandoned
          output_phase_next      = PH_IDLE;
          pad_remaining_next     = 10'd0;
          trailer_remaining_next = 8'd0;
          tick_timer_next        = '0;
          second_half_next       = 1'b0;
          bit_position_next      = 3'd0;
        end else if (!expire) begin
          tick_timer_next = timer_inc[TIMER_WIDTH-1:0];
        end else begin
          tick_timer_next = '0;
          if (!second_half) begin
            second_half_next = 1'b1;
            line_level_next  = 1'b1;
          end else begin
            second_half_next = 1'b0;
            if (bit_position != 3'd7) begin
              bit_position_next = bit_position + 3'd1;
              line_level_next   = 1'b0;
            end else if (output_phase == PH_PAD && pad_remaining != 10'd0) begin
              // another padding byte
              pad_remaining_next = pad_remaining - 10'd1;
              output_phase_next  = PH_PAD;
              shift_byte_next    = LEADER_BYTE;
              bit_position_next  = 3'd0;
              line_level_next    = 1'b0;
            end else if (output_phase == PH_PAD) begin
              // padding done, play the held byte
              output_phase_next = PH_DATA;
              shift_byte_next   = held_byte;
              bit_position_next = 3'd0;
              line_level_next   = 1'b0;
            end else if (trailer_remaining != 8'd0) begin
              trailer_remaining_next = trailer_remaining - 8'd1;
              output_phase_next      = PH_TRAIL;
              shift_byte_next        = LEADER_BYTE;
              bit_position_next      = 3'd0;
              line_level_next        = 1'b0;
            end else begin
              output_phase_next = PH_IDLE;
              bit_position_next = 3'd0;
            end
          end
        end
      end
    end else if (output_phase != PH_IDLE) begin
      // byte offered while busy
      dropped = 1'b1;
    end else begin
      // leader run bookkeeping
      if (q_data.is_leader) begin
        if (leader_run != RUN_MAX) begin
          leader_run_next = leader_run + 10'd1;
        end
      end else begin
        leader_run_next = 10'd0;
      end
      if (q_data.is_last) begin
        leader_run_next = 10'd0;
      end
      if (enable) begin
        if (!q_data.is_zero && (nonzero_total != {COUNT_WIDTH{1'b1}})) begin
          nonzero_total_next = nonzero_total + COUNT_WIDTH'(1);
        end
        held_byte_next         = q_data.data_byte;
        trailer_remaining_next = q_data.is_last ? trailer_bytes : 8'd0;
        bit_position_next      = 3'd0;
        second_half_next       = 1'b0;
        tick_timer_next        = '0;
        line_level_next        = 1'b0;
        if (do_pad && !q_data.is_leader) begin
          pad_remaining_next = pad_value - 10'd1;
          output_phase_next  = PH_PAD;
          shift_byte_next    = LEADER_BYTE;
        end else begin
          pad_remaining_next = 10'd0;
          output_phase_next  = PH_DATA;
          shift_byte_next    = q_data.data_byte;
        end
      end
    end
  end

  // state registers, advanced on each item taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_run        <= 10'd0;
      pad_remaining     <= 10'd0;
      trailer_remaining <= 8'd0;
      held_byte         <= 8'd0;
      shift_byte        <= 8'd0;
      bit_position      <= 3'd0;
      second_half       <= 1'b0;
      tick_timer        <= '0;
      output_phase      <= PH_IDLE;
      line_level        <= 1'b0;
      nonzero_total     <= '0;
    end else if (q_pop) begin
      leader_run        <= leader_run_next;
      pad_remaining     <= pad_remaining_next;
      trailer_remaining <= trailer_remaining_next;
      held_byte         <= held_byte_next;
      shift_byte        <= shift_byte_next;
      bit_position      <= bit_position_next;
      second_half       <= second_half_next;
      tick_timer        <= tick_timer_next;
      output_phase      <= output_phase_next;
      line_level        <= line_level_next;
      nonzero_total     <= nonzero_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.audio_level   <= line_level_next;
      out_data.ready_res     <= (output_phase_next == PH_IDLE);
      out_data.dropped       <= dropped;
      out_data.nonzero_count <= OUT_COUNT_WIDTH'(nonzero_total_next);
    end
  end

endmodule

// ===== sv/cassette_fsk_tape_encoder.sv =====
// cassette fsk tape encoder
// req: request items; req_type 0 offers a tape byte (with its lookahead and
//   last-byte flag), req_type 1 is one timing tick from the prescaler.
// res: exactly one result per request, in order: line level, idle flag,
//   dropped flag for a byte offered while busy, saturating nonzero count.
// cfg: register writes (index, value), always ready; write only while idle.
// throughput: one request per clock while res.ready stays high; the whole state
//   update for an item is computed at once in the back end, so the serialiser, tick timer
//   and leader counter set the pace, not a loop.
// path: a request is written into the two-entry queue, then its result into the
//   result register, from which res takes it; while that register holds an
//   untaken result, the queue is not popped.
// reset: queue and result register empty, playback idle, line low, counters
//   cleared, registers back to their defaults; req.ready is high afterwards.
// stall: when res.ready is low the result holds; the queue takes up to two
//   more requests, then req.ready drops until results are taken.
module cassette_fsk_tape_encoder
  import cfe_pkg::*;
#(
  parameter int TIMER_WIDTH = DEF_TIMER_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  cfe_chan_if.sink   req,
  cfe_chan_if.source res,
  cfe_chan_if.sink   cfg
);

  logic      q_valid;
  cls_item_t q_data;
  logic      q_pop;

  // accept and classify
  cfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // playback engine
  cfe_back #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .res     (res)
  );

endmodule

// ===== sv/cfe_checker.sv =====
`include "cassette_fsk_tape_encoder_assert.svh"

module cfe_checker
  import cfe_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       res_level,
  input logic                       res_idle,
  input logic                       res_dropped,
  input logic [OUT_COUNT_WIDTH-1:0] res_count
);

  // a discarded byte means playback was running and still is
  `CFE_ASSERT_NOW(a_dropped_busy, res_valid && res_dropped, !res_idle, "dropped while idle")

  // nonzero count never goes down between back-to-back results
  `CFE_ASSERT_NOW(a_count_mono, res_valid && res_ready ##1 res_valid,
    res_count >= $past(res_count), "nonzero count decreased")

  // a stalled result holds
  `CFE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(res_level) && $stable(res_idle) && $stable(res_dropped)
    && $stable(res_count), "stalled result changed")

  // reset empties the result register and leaves the queue ready
  `CFE_ASSERT_RESET(a_reset_empty, !res_valid && req_ready, "not empty after reset")

endmodule

bind cassette_fsk_tape_encoder cfe_checker u_cfe_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_level   (res.data.audio_level),
  .res_idle    (res.data.ready_res),
  .res_dropped (res.data.dropped),
  .res_count   (res.data.nonzero_count)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cfe_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_OFF    = 3;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one step of the directed sequence: a request or a register write
  typedef struct packed {
    row_kind_t kind;
    in_item_t  item;
    logic      settle;
    logic      typed;
    out_item_t want;
    cfg_item_t reg_wr;
  } step_row_t;

  // one register setting for a stretch of random files
  typedef struct {
    logic [15:0] hz;
    logic [15:0] h1;
    logic [9:0]  len;
    logic [9:0]  orph;
    logic [7:0]  trail;
    logic        en;
    int          bytes;
    bit          calm;
  } tape_setting_t;

  localparam in_item_t  TICK_IT = '{REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0};
  localparam in_item_t  NO_ITEM = '0;
  localparam out_item_t NO_WANT = '0;
  localparam cfg_item_t NO_REG  = '0;

  logic clk = 1'b0;
  logic rst;

  cfe_chan_if #(.T(in_item_t))  req_if ();
  cfe_chan_if #(.T(out_item_t)) res_if ();
  cfe_chan_if #(.T(cfg_item_t)) cfg_if ();

  cassette_fsk_tape_encoder u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copy held by the line predictor
  logic [15:0] cfg_hz    = RST_HALF_ZERO;
  logic [15:0] cfg_h1    = RST_HALF_ONE;
  logic [9:0]  cfg_len   = RST_LEADER_LEN;
  logic [9:0]  cfg_orph  = RST_ORPHAN_MIN;
  logic [7:0]  cfg_trail = RST_TRAILER;
  logic        cfg_en    = RST_ENABLE;

  // playback state held by the line predictor
  logic [9:0]  tape_lead       = '0;
  logic [9:0]  tape_pad_left   = '0;
  logic [7:0]  tape_trail_left = '0;
  logic [7:0]  tape_held       = '0;
  logic [7:0]  tape_shift      = '0;
  logic [2:0]  tape_bit        = '0;
  logic        tape_second     = 1'b0;
  logic [15:0] tape_timer      = '0;
  logic [1:0]  tape_phase      = PH_IDLE;
  logic        tape_level      = 1'b0;
  logic [23:0] tape_nonzero    = '0;

  out_item_t line_expect_q[$];
  int        fault_count = 0;
  int        bytes_left  = 0;
  int        stall_cycles = 0;
  bit        calm = 1'b0;

  // directed sequence: reset behaviour, busy drop, abandon, then the leader rules, trailer and half periods
  step_row_t dir_rows [35] = '{
    '{ROW_ITEM, TICK_IT, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 24'd0}, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 24'd0}, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b1, 24'd0}, NO_REG},
    '{ROW_ITEM, TICK_IT, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 24'd0}, NO_REG},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_ENABLE, 16'd0}},
    // tick while busy and disabled drops playback
    '{ROW_ITEM, TICK_IT, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 24'd0}, NO_REG},
    // disabled leader byte is tracked but not played
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 24'd0}, NO_REG},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ZERO, 16'd2}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ONE, 16'd1}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_LEADER_LEN, 16'd3}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_ORPHAN_MIN, 16'd2}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_TRAILER, 16'd1}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_ENABLE, 16'd1}},
    // sync with block type 1 pads the short leader
    '{ROW_ITEM, '{REQ_BYTE, SYNC_BYTE, 8'h01, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // block type above one, no pad
    '{ROW_ITEM, '{REQ_BYTE, SYNC_BYTE, 8'h02, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // lookahead past the end of file, no pad
    '{ROW_ITEM, '{REQ_BYTE, SYNC_BYTE, 8'h00, 1'b0, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // orphan leader at the minimum is padded
    '{ROW_ITEM, '{REQ_BYTE, 8'hA7, 8'h55, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // orphan leader below the minimum
    '{ROW_ITEM, '{REQ_BYTE, 8'h12, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // empty leader before sync
    '{ROW_ITEM, '{REQ_BYTE, SYNC_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_ORPHAN_MIN, 16'd0}},
    // empty leader with orphan minimum zero
    '{ROW_ITEM, '{REQ_BYTE, 8'h80, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_ITEM, '{REQ_BYTE, LEADER_BYTE, 8'h00, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    // last byte: padded orphan then trailer
    '{ROW_ITEM, '{REQ_BYTE, 8'h33, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ZERO, 16'd0}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ONE, 16'd65535}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_TRAILER, 16'd0}},
    // zero half period runs as one tick
    '{ROW_ITEM, '{REQ_BYTE, 8'h00, 8'hFF, 1'b1, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ZERO, 16'd65535}},
    '{ROW_REG, NO_ITEM, 1'b0, 1'b0, NO_WANT, '{REG_HALF_ONE, 16'd1}},
    '{ROW_ITEM, '{REQ_BYTE, 8'hFF, 8'h01, 1'b0, 1'b0}, 1'b1, 1'b0, NO_WANT, NO_REG}
  };

  // register settings for the random files, extremes included
  tape_setting_t tape_settings [8] = '{
    '{16'd2, 16'd1, 10'd4,    10'd2,    8'd2,   1'b1, 120, 1'b0},
    '{16'd1, 16'd3, 10'd6,    10'd0,    8'd0,   1'b1, 100, 1'b0},
    '{16'd3, 16'd2, 10'd1,    10'd1,    8'd3,   1'b1, 80,  1'b0},
    '{16'd1, 16'd1, 10'd5,    10'd1023, 8'd0,   1'b1, 80,  1'b0},
    '{16'd1, 16'd2, 10'd8,    10'd0,    8'd0,   1'b0, 60,  1'b0},
    '{16'd1, 16'd2, 10'd8,    10'd0,    8'd1,   1'b1, 80,  1'b0},
    '{16'd1, 16'd1, 10'd1023, 10'd0,    8'd255, 1'b1, 8,   1'b0},
    '{16'd4, 16'd2, 10'd10,   10'd3,    8'd1,   1'b1, 100, 1'b1}
  };

  // start serialising a byte from its first low half
  task automatic load_tape_byte(input logic [1:0] ph, input logic [7:0] v);
    tape_phase  = ph;
    tape_shift  = v;
    tape_bit    = '0;
    tape_second = 1'b0;
    tape_timer  = '0;
    tape_level  = 1'b0;
  endtask

  // line predictor: advance the encoder by one request
  task automatic predict_tape_line(input in_item_t it, output out_item_t r);
    int   half;
    int   pad;
    logic turned_away;
    pad = 0;
    turned_away = 1'b0;
    if (it.req_type == REQ_TICK) begin
      if (tape_phase != PH_IDLE) begin
        if (!cfg_en) begin
          tape_phase      = PH_IDLE;
          tape_pad_left   = '0;
          tape_trail_left = '0;
          tape_timer      = '0;
          tape_second     = 1'b0;
          tape_bit        = '0;
        end else begin
          half = tape_shift[tape_bit] ? int'(cfg_h1) : int'(cfg_hz);
          if (half == 0) half = 1;
          if (int'(tape_timer) + 1 < half) begin
            tape_timer = tape_timer + 16'd1;
          end else begin
            tape_timer = '0;
            if (!tape_second) begin
              tape_second = 1'b1;
              tape_level  = 1'b1;
            end else begin
              tape_second = 1'b0;
              if (tape_bit != 3'd7) begin
                tape_bit   = tape_bit + 3'd1;
                tape_level = 1'b0;
              end else if (tape_phase == PH_PAD && tape_pad_left != 0) begin
                tape_pad_left = tape_pad_left - 10'd1;
                load_tape_byte(PH_PAD, LEADER_BYTE);
              end else if (tape_phase == PH_PAD) begin
                load_tape_byte(PH_DATA, tape_held);
              end else if (tape_trail_left != 0) begin
                tape_trail_left = tape_trail_left - 8'd1;
                load_tape_byte(PH_TRAIL, LEADER_BYTE);
              end else begin
                tape_phase = PH_IDLE;
                tape_bit   = '0;
              end
            end
          end
        end
      end
    end else if (tape_phase != PH_IDLE) begin
      turned_away = 1'b1;
    end else begin
      // leader run tracking and pad decision
      if (it.data_byte == LEADER_BYTE) begin
        if (tape_lead != RUN_MAX) tape_lead = tape_lead + 10'd1;
      end else begin
        if (it.data_byte == SYNC_BYTE) begin
          if (it.next_valid && it.next_byte <= BLOCK_TYPE_MAX && tape_lead != 0 &&
              tape_lead < cfg_len)
            pad = int'(cfg_len) - int'(tape_lead);
        end else if (tape_lead != 0 && tape_lead >= cfg_orph && tape_lead < cfg_len) begin
          pad = int'(cfg_len) - int'(tape_lead);
        end
        tape_lead = '0;
      end
      if (it.is_last) tape_lead = '0;
      if (cfg_en) begin
        if (it.data_byte != 8'h00 && tape_nonzero != '1) tape_nonzero = tape_nonzero + 24'd1;
        tape_held       = it.data_byte;
        tape_trail_left = it.is_last ? cfg_trail : 8'd0;
        if (pad > 0) begin
          tape_pad_left = 10'(pad - 1);
          load_tape_byte(PH_PAD, LEADER_BYTE);
        end else begin
          tape_pad_left = '0;
          load_tape_byte(PH_DATA, it.data_byte);
        end
      end
    end
    r.audio_level   = tape_level;
    r.ready_res     = (tape_phase == PH_IDLE);
    r.dropped       = turned_away;
    r.nonzero_count = tape_nonzero;
  endtask

  // offer one request, with random idle cycles first
  task automatic send_req(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    while (!calm && $urandom_range(99) < 17) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_tape_line(it, predicted);
    line_expect_q.push_back(typed ? want : predicted);
  endtask

  // hold the sender until every expected result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (line_expect_q.size() != 0);
  endtask

  // register write, only with nothing in flight
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_item_t wr;
    wait_drained();
    repeat (HOLD_OFF) @(posedge clk);
    wr.index = idx;
    wr.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_HALF_ZERO:  cfg_hz    = val;
      REG_HALF_ONE:   cfg_h1    = val;
      REG_LEADER_LEN: cfg_len   = val[9:0];
      REG_ORPHAN_MIN: cfg_orph  = val[9:0];
      REG_TRAILER:    cfg_trail = val[7:0];
      REG_ENABLE:     cfg_en    = val[0];
      default: ;
    endcase
  endtask

  // tick until playback has finished
  task automatic run_to_idle();
    while (tape_phase != PH_IDLE) send_req(TICK_IT, 1'b0, NO_WANT);
  endtask

  function automatic logic [7:0] random_byte();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // play one byte with occasional drops, abandons, idle ticks and pauses
  task automatic feed_tape_byte(input logic [7:0] b, input logic [7:0] nb, input logic nv,
                                input logic last);
    in_item_t it;
    in_item_t stray;
    it = '{REQ_BYTE, b, nb, nv, last};
    send_req(it, 1'b0, NO_WANT);
    bytes_left--;
    if ($urandom_range(5) == 0) begin
      stray = '{REQ_BYTE, random_byte(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1))};
      send_req(stray, 1'b0, NO_WANT);
      bytes_left--;
    end
    if (cfg_en && tape_phase != PH_IDLE && $urandom_range(24) == 0) begin
      write_reg(REG_ENABLE, 16'd0);
      send_req(TICK_IT, 1'b0, NO_WANT);
      write_reg(REG_ENABLE, 16'd1);
    end
    run_to_idle();
    if ($urandom_range(7) == 0) send_req(TICK_IT, 1'b0, NO_WANT);
    if ($urandom_range(39) == 0) wait_drained();
  endtask

  // one tape file: leader run, sync or other byte, then a short body
  task automatic play_file();
    int         run_cap;
    int         hi;
    int         lead_n;
    int         body_n;
    int         pick;
    logic [7:0] nb;
    run_cap = (int'(cfg_len) + 3 < 40) ? int'(cfg_len) + 3 : 40;
    hi = (cfg_len > 1) ? int'(cfg_len) - 1 : 1;
    if (hi > run_cap) hi = run_cap;
    pick = $urandom_range(9);
    if (pick < 2) lead_n = 0;
    else if (pick < 6) lead_n = $urandom_range(hi, 1);
    else if (pick < 8)
      lead_n = (int'(cfg_len) + 2 <= run_cap) ?
               $urandom_range(int'(cfg_len) + 2, int'(cfg_len)) : run_cap;
    else lead_n = $urandom_range(run_cap, 0);
    repeat (lead_n)
      feed_tape_byte(LEADER_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
    body_n = $urandom_range(3);
    if ($urandom_range(9) < 6) begin
      pick = $urandom_range(3);
      nb = (pick == 0) ? 8'h00 : (pick == 1) ? BLOCK_TYPE_MAX : 8'($urandom_range(255));
      feed_tape_byte(SYNC_BYTE, nb, $urandom_range(9) != 0,
                     body_n == 0 && $urandom_range(1) == 1);
    end else begin
      feed_tape_byte(random_byte(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                     body_n == 0 && $urandom_range(1) == 1);
    end
    for (int k = 0; k < body_n; k++)
      feed_tape_byte(random_byte(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                     k == body_n - 1 && $urandom_range(3) != 0);
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want_r;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (line_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, res_if.data);
          fault_count++;
        end else begin
          want_r = line_expect_q.pop_front();
          report_field("audio_level", want_r.audio_level, res_if.data.audio_level);
          report_field("ready_res", want_r.ready_res, res_if.data.ready_res);
          report_field("dropped", want_r.dropped, res_if.data.dropped);
          report_field("nonzero_count", want_r.nonzero_count, res_if.data.nonzero_count);
        end
      end
      res_if.ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed steps
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].reg_wr.index, dir_rows[i].reg_wr.value);
      end else begin
        send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        if (dir_rows[i].settle) run_to_idle();
      end
    end

    // random files under each setting
    for (int p = 0; p < 8; p++) begin
      calm = tape_settings[p].calm;
      write_reg(REG_HALF_ZERO, tape_settings[p].hz);
      write_reg(REG_HALF_ONE, tape_settings[p].h1);
      write_reg(REG_LEADER_LEN, 16'(tape_settings[p].len));
      write_reg(REG_ORPHAN_MIN, 16'(tape_settings[p].orph));
      write_reg(REG_TRAILER, 16'(tape_settings[p].trail));
      write_reg(REG_ENABLE, 16'(tape_settings[p].en));
      // leader run left over from the disabled stretch
      if (p > 0 && !tape_settings[p - 1].en) feed_tape_byte(SYNC_BYTE, 8'h00, 1'b1, 1'b0);
      bytes_left = tape_settings[p].bytes;
      while (bytes_left > 0) play_file();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cfe_pkg.sv
sv/cfe_chan_if.sv
sv/cfe_front.sv
sv/cfe_back.sv
sv/cassette_fsk_tape_encoder.sv
sv/cfe_checker.sv
tb/sv/tb.sv
